// ----- rtl/core/page_frame_table_lookup_assert.svh -----
// ----------------------------------------------------------------------------
// Page frame table lookup: assertion macros
// Short forms for the concurrent checks used in the RTL. Each form samples
// on clk and is switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_TABLE_LOOKUP_ASSERT_SVH
`define PAGE_FRAME_TABLE_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pftl_pkg.sv -----
// ----------------------------------------------------------------------------
// Page frame table lookup: shared package
// Sizes, result codes, command and status types and small helper functions
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pftl_pkg;

	// Table geometry and counter width.
	localparam int FRAMES     = 16;
	localparam int PAGE_BITS  = 16;
	localparam int COUNT_BITS = 32;

	// Fixed widths of the port fields.
	localparam int PAGE_IN_W   = 16;
	localparam int OUTCOME_W   = 2;
	localparam int INDEX_OUT_W = 4;
	localparam int OUT_BITS    = 32;

	// Derived widths.
	localparam int PAGE_W   = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
	localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [PAGE_W-1:0]     page_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [OUTCOME_W-1:0]  outcome_t;

	localparam count_t COUNT_MAX  = '1;
	localparam idx_t   LAST_FRAME = IDX_BITS'(FRAMES - 1);

	// Result codes.
	localparam outcome_t OUT_HIT   = OUTCOME_W'(0);
	localparam outcome_t OUT_FILL  = OUTCOME_W'(1);
	localparam outcome_t OUT_FAULT = OUTCOME_W'(2);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic update;
	} pftl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} pftl_status_t;

	// Saturating increment of a counter.
	function automatic count_t sat_inc(input count_t v);
		return (v == COUNT_MAX) ? v : v + count_t'(1);
	endfunction

	// Low bits of a counter, zero extended where the counter is narrow.
	function automatic logic [OUT_BITS-1:0] count_out(input count_t v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[OUT_BITS-1:0];
	endfunction

	// Low bits of a frame number.
	function automatic logic [INDEX_OUT_W-1:0] index_out(input idx_t v);
		logic [15:0] wide;
		wide = 16'(v);
		return wide[INDEX_OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/page_frame_table_lookup.sv -----
// ----------------------------------------------------------------------------
// Page frame table lookup: top level
// Looks up each page reference in a table of physical frames, fills the
// lowest empty frame on a miss and keeps saturating access and fault counts.
// ----------------------------------------------------------------------------
// Usage:
// A reference is transferred at a rising edge where start is high and busy
// is low; page is sampled at that edge. busy stays high while the reference
// is in work, and one reference is handled at a time.
// The controller scans the frame table one frame per cycle through the
// registered read port of the table memories, then passes through a drain
// state for the last compare and an update state. The result is registered
// from the update state; busy falls in the same cycle as the result appears,
// so a new reference can be transferred then.
// Each result is shown for exactly one cycle with done high and cannot be
// held off by the receiver; fill_total and fault_total keep their values
// until the next result.
// Reset clears the valid bits of every frame and both running counts; page
// numbers and access counts are written on the first fill of each frame, so
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_frame_table_lookup
	import pftl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [PAGE_IN_W-1:0]  page,
	output logic                       done,
	output logic [OUTCOME_W-1:0]       outcome,
	output logic [INDEX_OUT_W-1:0]     frame_index,
	output logic [OUT_BITS-1:0]        frame_count,
	output logic [OUT_BITS-1:0]        fill_total,
	output logic [OUT_BITS-1:0]        fault_total
);

	pftl_cmd_t    cmd;
	pftl_status_t status;

	// Sequencer.
	pftl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	// Frame table and counters.
	pftl_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.page        (page),
		.done        (done),
		.outcome     (outcome),
		.frame_index (frame_index),
		.frame_count (frame_count),
		.fill_total  (fill_total),
		.fault_total (fault_total)
	);

endmodule

`default_nettype wire

// ----- rtl/core/pftl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page frame table lookup: controller
// Sequences one reference: load, scan of every frame, a drain state for the
// last compare, and the update that produces the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pftl_ctrl
	import pftl_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	output pftl_cmd_t         cmd,
	input  wire pftl_status_t status
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Commands to the datapath.
	always_comb begin
		busy       = (state_q != ST_IDLE);
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.update = (state_q == ST_UPDATE);
	end

endmodule

`default_nettype wire

// ----- rtl/core/pftl_datapath.sv -----
// ----------------------------------------------------------------------------
// Page frame table lookup: datapath
// Holds the frame table and counters, scans one frame a cycle for a hit and
// for the lowest empty frame, and applies the update that forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "page_frame_table_lookup_assert.svh"

module pftl_datapath
	import pftl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pftl_cmd_t              cmd,
	output pftl_status_t                status,
	input  wire logic [PAGE_IN_W-1:0]   page,
	output logic                        done,
	output logic [OUTCOME_W-1:0]        outcome,
	output logic [INDEX_OUT_W-1:0]      frame_index,
	output logic [OUT_BITS-1:0]         frame_count,
	output logic [OUT_BITS-1:0]         fill_total,
	output logic [OUT_BITS-1:0]         fault_total
);

	// Frame table storage.
	logic   [FRAMES-1:0] frame_valid_q;
	page_t               page_mem [FRAMES];
	count_t              count_mem [FRAMES];

	// Reference under lookup and scan address.
	page_t  page_q;
	idx_t   addr_q;

	// Registered read of the frame at the scan address.
	logic   rd_en_s1;
	idx_t   addr_s1;
	logic   valid_s1;
	page_t  page_s1;
	count_t count_s1;

	// Scan findings.
	logic   hit_found_q;
	idx_t   hit_idx_q;
	count_t hit_cnt_q;
	logic   empty_found_q;
	idx_t   empty_idx_q;

	// Running totals.
	count_t fill_count_q;
	count_t fault_count_q;

	// Result registers.
	logic     done_q;
	outcome_t outcome_q;
	idx_t     res_idx_q;
	count_t   res_cnt_q;

	// Update decode.
	logic   cnt_we;
	idx_t   cnt_waddr;
	count_t cnt_wdata;
	logic   fill_we;

	assign status.last = cmd.scan && (addr_q == LAST_FRAME);

	// Capture the page and step the scan address.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page[PAGE_W-1:0];
			addr_q <= '0;
		end else if (cmd.scan && (addr_q != LAST_FRAME)) begin
			addr_q <= addr_q + idx_t'(1);
		end
	end

	// Read stage: one frame per cycle with registered data.
	always_ff @(posedge clk) begin
		page_s1  <= page_mem[addr_q];
		count_s1 <= count_mem[addr_q];
		valid_s1 <= frame_valid_q[addr_q];
		addr_s1  <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan;
		end
	end

	// Compare stage: the first matching frame and the first empty frame win.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmd.load) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (rd_en_s1) begin
			if (valid_s1) begin
				if (!hit_found_q && (page_s1 == page_q)) begin
					hit_found_q <= 1'b1;
				end
			end else if (!empty_found_q) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_s1 && valid_s1 && !hit_found_q && (page_s1 == page_q)) begin
			hit_idx_q <= addr_s1;
			hit_cnt_q <= count_s1;
		end
		if (rd_en_s1 && !valid_s1 && !empty_found_q) begin
			empty_idx_q <= addr_s1;
		end
	end

	// Decode the table writes of the update cycle.
	always_comb begin
		cnt_we    = cmd.update && (hit_found_q || empty_found_q);
		cnt_waddr = hit_found_q ? hit_idx_q : empty_idx_q;
		cnt_wdata = hit_found_q ? sat_inc(hit_cnt_q) : '0;
		fill_we   = cmd.update && !hit_found_q && empty_found_q;
	end

	// Table memories.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[cnt_waddr] <= cnt_wdata;
		end
		if (fill_we) begin
			page_mem[empty_idx_q] <= page_q;
		end
	end

	// Frame valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
		end else if (fill_we) begin
			frame_valid_q[empty_idx_q] <= 1'b1;
		end
	end

	// Running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q  <= '0;
			fault_count_q <= '0;
		end else if (cmd.update && !hit_found_q) begin
			if (empty_found_q) begin
				fill_count_q <= sat_inc(fill_count_q);
			end else begin
				fault_count_q <= sat_inc(fault_count_q);
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (hit_found_q) begin
				outcome_q <= OUT_HIT;
				res_idx_q <= hit_idx_q;
				res_cnt_q <= sat_inc(hit_cnt_q);
			end else if (empty_found_q) begin
				outcome_q <= OUT_FILL;
				res_idx_q <= empty_idx_q;
				res_cnt_q <= '0;
			end else begin
				outcome_q <= OUT_FAULT;
				res_idx_q <= '0;
				res_cnt_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign outcome     = outcome_q;
	assign frame_index = index_out(res_idx_q);
	assign frame_count = count_out(res_cnt_q);
	assign fill_total  = count_out(fill_count_q);
	assign fault_total = count_out(fault_count_q);

	// Checks.
	`PFTL_ASSERT_NEXT(a_update_gives_result, cmd.update, done,
		"update cycle not followed by a result")
	`PFTL_ASSERT_NOW(a_outcome_code, done,
		(outcome == OUT_HIT) || (outcome == OUT_FILL) || (outcome == OUT_FAULT),
		"result carries an unknown outcome")
	`PFTL_ASSERT_NOW(a_fault_zero, done && (outcome == OUT_FAULT),
		(frame_index == '0) && (frame_count == '0),
		"fault result with non-zero frame fields")
	`PFTL_ASSERT_NOW(a_fill_zero_count, done && (outcome == OUT_FILL),
		frame_count == '0, "fill result with non-zero access count")

endmodule

`default_nettype wire
